>>> rtl/hlte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlte_pkg
// Shared types, constants and helpers of the held-lock table edge emitter.
// ----------------------------------------------------------------------------
package hlte_pkg;

    // table geometry
    localparam int THREAD_SLOTS    = 64;
    localparam int HELD_PER_THREAD = 16;
    localparam int MEM_DEPTH       = THREAD_SLOTS * HELD_PER_THREAD;

    localparam int ROW_W   = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int ENTRY_W = (HELD_PER_THREAD > 1) ? $clog2(HELD_PER_THREAD) : 1;
    localparam int MEM_AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // field widths
    localparam int SLOT_W  = 6;
    localparam int PROC_W  = 32;
    localparam int LOCK_W  = 64;
    localparam int STACK_W = 64;

    // request codes
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // result kinds
    localparam logic KIND_EDGE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_HELD = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic               req_type;
        logic [SLOT_W-1:0]  thread_slot;
        logic [PROC_W-1:0]  process_id;
        logic [LOCK_W-1:0]  lock_addr;
        logic [STACK_W-1:0] call_stack_id;
    } in_item_t;

    typedef struct packed {
        logic               item_kind;
        logic [PROC_W-1:0]  edge_process;
        logic [SLOT_W-1:0]  edge_thread;
        logic [LOCK_W-1:0]  from_lock;
        logic [STACK_W-1:0] from_stack;
        logic [LOCK_W-1:0]  to_lock;
        logic [STACK_W-1:0] to_stack;
        logic [1:0]         status_code;
        logic               last_item;
    } out_item_t;

    // one table entry
    typedef struct packed {
        logic [LOCK_W-1:0]  addr;
        logic [STACK_W-1:0] stack;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic               load;
        logic               rd_en;
        logic [ENTRY_W-1:0] rd_idx;
        logic [ENTRY_W-1:0] cur_idx;
        logic               scan_chk;
        logic               emit_edge;
        logic               store;
        logic               emit_status;
        logic               clr_en;
        logic [MEM_AW-1:0]  clr_addr;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_release;
        logic hit;
        logic occupied;
        logic out_free;
    } sts_t;

    // row of the table for an input slot
    function automatic logic [ROW_W-1:0] slot_row(input logic [SLOT_W-1:0] slot);
        int unsigned r;
        r = int'(slot) % THREAD_SLOTS;
        return ROW_W'(r);
    endfunction

    // flat memory address of one entry
    function automatic logic [MEM_AW-1:0] entry_addr(input logic [ROW_W-1:0]   row,
                                                     input logic [ENTRY_W-1:0] idx);
        int unsigned a;
        a = int'(row) * HELD_PER_THREAD + int'(idx);
        return MEM_AW'(a);
    endfunction

endpackage

>>> rtl/hlte_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlte_ctrl
// Sequencer: clearing pass, match scan, edge emission, store and status.
// ----------------------------------------------------------------------------
module hlte_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  hlte_pkg::sts_t sts,
    output hlte_pkg::cmd_t cmd
);
    import hlte_pkg::*;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CHK = 3'd3;
    localparam logic [2:0] S_EMIT_RD  = 3'd4;
    localparam logic [2:0] S_EMIT_CHK = 3'd5;
    localparam logic [2:0] S_STORE    = 3'd6;
    localparam logic [2:0] S_STATUS   = 3'd7;

    localparam logic [ENTRY_W-1:0] LAST_IDX = ENTRY_W'(HELD_PER_THREAD - 1);
    localparam logic [MEM_AW-1:0]  LAST_CLR = MEM_AW'(MEM_DEPTH - 1);

    logic [2:0]         state_reg, state_next;
    logic [ENTRY_W-1:0] idx_reg, idx_next;
    logic [MEM_AW-1:0]  clr_cnt_reg, clr_cnt_next;

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            idx_reg     <= '0;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        clr_cnt_next = clr_cnt_reg;
        cmd          = '0;
        cmd.cur_idx  = idx_reg;
        cmd.clr_addr = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (clr_cnt_reg == LAST_CLR) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_idx = '0;
                idx_next   = '0;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                cmd.scan_chk = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    if (sts.is_release || sts.hit) begin
                        state_next = S_STATUS;
                    end else begin
                        state_next = S_EMIT_RD;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_idx = idx_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                end
            end
            S_EMIT_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_idx = '0;
                idx_next   = '0;
                state_next = S_EMIT_CHK;
            end
            S_EMIT_CHK: begin
                // empty entries pass straight on, occupied ones wait for the output
                if (!sts.occupied || sts.out_free) begin
                    cmd.emit_edge = sts.occupied;
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_STORE;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_idx = idx_reg + 1'b1;
                        idx_next   = idx_reg + 1'b1;
                    end
                end
            end
            S_STORE: begin
                cmd.store  = 1'b1;
                state_next = S_STATUS;
            end
            S_STATUS: begin
                if (sts.out_free) begin
                    cmd.emit_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

>>> rtl/hlte_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlte_dpath
// Held-lock table memory, request register, scan flags and output register.
// ----------------------------------------------------------------------------
module hlte_dpath (
    input  logic                aclk,
    input  logic                aresetn,
    input  hlte_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hlte_pkg::out_item_t m_data,
    input  hlte_pkg::cmd_t      cmd,
    output hlte_pkg::sts_t      sts
);
    import hlte_pkg::*;

    entry_t             mem [MEM_DEPTH];
    entry_t             rd_data_reg;
    in_item_t           req_reg;
    logic               hit_reg;
    logic               free_found_reg;
    logic [ENTRY_W-1:0] free_idx_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic [ROW_W-1:0]   row;
    logic               cur_match;
    logic               cur_empty;
    logic               is_release;
    logic               out_free;
    logic               wr_en;
    logic [MEM_AW-1:0]  wr_addr;
    entry_t             wr_data;
    logic [1:0]         final_status;
    out_item_t          edge_item;
    out_item_t          status_item;

    assign row        = slot_row(req_reg.thread_slot);
    assign is_release = (req_reg.req_type == REQ_RELEASE);
    assign cur_match  = (rd_data_reg.addr == req_reg.lock_addr);
    assign cur_empty  = (rd_data_reg.addr == '0);
    assign out_free   = !m_valid_reg || m_ready;

    // request word
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_data;
        end
    end

    // write port: clearing pass, release of a matching entry, store of new lock
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cmd.clr_addr;
        wr_data = '0;
        priority if (cmd.clr_en) begin
            wr_en = 1'b1;
        end else if (cmd.scan_chk && is_release && cur_match) begin
            wr_en   = 1'b1;
            wr_addr = entry_addr(row, cmd.cur_idx);
        end else if (cmd.store && free_found_reg) begin
            wr_en         = 1'b1;
            wr_addr       = entry_addr(row, free_idx_reg);
            wr_data.addr  = req_reg.lock_addr;
            wr_data.stack = req_reg.call_stack_id;
        end
    end

    // table memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[entry_addr(row, cmd.rd_idx)];
        end
    end

    // match and first-free tracking over the scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.load) begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.scan_chk && !is_release) begin
            if (cur_match) begin
                hit_reg <= 1'b1;
            end
            if (cur_empty && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_chk && cur_empty && !free_found_reg) begin
            free_idx_reg <= cmd.cur_idx;
        end
    end

    // result words
    always_comb begin
        priority if (is_release) begin
            final_status = ST_OK;
        end else if (hit_reg) begin
            final_status = ST_HELD;
        end else if (free_found_reg) begin
            final_status = ST_OK;
        end else begin
            final_status = ST_FULL;
        end

        edge_item              = '0;
        edge_item.item_kind    = KIND_EDGE;
        edge_item.edge_process = req_reg.process_id;
        edge_item.edge_thread  = req_reg.thread_slot;
        edge_item.from_lock    = rd_data_reg.addr;
        edge_item.from_stack   = rd_data_reg.stack;
        edge_item.to_lock      = req_reg.lock_addr;
        edge_item.to_stack     = req_reg.call_stack_id;
        edge_item.status_code  = ST_OK;
        edge_item.last_item    = 1'b0;

        status_item             = '0;
        status_item.item_kind   = KIND_STATUS;
        status_item.status_code = final_status;
        status_item.last_item   = 1'b1;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_edge || cmd.emit_status) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_edge) begin
            m_data_reg <= edge_item;
        end else if (cmd.emit_status) begin
            m_data_reg <= status_item;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;
    assign sts.is_release = is_release;
    assign sts.hit        = hit_reg || cur_match;
    assign sts.occupied   = !cur_empty;
    assign sts.out_free   = out_free;

endmodule

>>> rtl/held_lock_table_edge_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// held_lock_table_edge_emitter
// Per-thread held-lock table that emits lock order edges on each acquire of a lock not already held.
// ----------------------------------------------------------------------------
// Release or acquire of a lock already held: one pass of the single table read
// port over the row. Other acquires: a match pass then an edge pass over the row,
// one entry per cycle, where an occupied entry in the edge pass waits while the
// output is stalled. Status is presented in the cycle the block is ready again.
// After reset a clearing pass writes all MEM_DEPTH (1024) entries, one a cycle,
// and no word is accepted until it finishes.
module held_lock_table_edge_emitter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hlte_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hlte_pkg::out_item_t m_data
);
    import hlte_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    hlte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // table and result path
    hlte_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

>>> rtl/hlte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlte_checker
// Port-level checks of the held-lock table edge emitter, bound to the top.
// ----------------------------------------------------------------------------
module hlte_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input hlte_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input hlte_pkg::out_item_t m_data
);
    import hlte_pkg::*;

    // reset starts the clearing pass with nothing on the output
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> (!s_ready && !m_valid))
        else $error("ready or valid high after reset");

    // one word at a time: ready drops after an accept
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted while busy");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // edges carry ok and are never final, statuses are always final
    a_kind_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.item_kind == KIND_EDGE && !m_data.last_item
                      && m_data.status_code == ST_OK)
                     || (m_data.item_kind == KIND_STATUS && m_data.last_item)))
        else $error("result kind and last flag disagree");

endmodule

bind held_lock_table_edge_emitter hlte_checker u_hlte_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
